// ----- hw/rtl/nnis_pkg.sv -----
// Shared constants and types of the nearest-neighbor image scaler.
`default_nettype none

package nnis_pkg;

  localparam int unsigned MAX_WIDTH  = 256;
  localparam int unsigned MAX_HEIGHT = 256;
  localparam int unsigned PIXEL_BITS = 16;

  localparam int unsigned DIM_W     = 9;
  localparam int unsigned CFG_IDX_W = 2;

  localparam int unsigned COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned ADDR_W = (MAX_WIDTH * MAX_HEIGHT > 1) ?
                                   $clog2(MAX_WIDTH * MAX_HEIGHT) : 1;
  localparam int unsigned CNT_W   = (COL_W > ROW_W) ? COL_W : ROW_W;
  localparam int unsigned DIV_N_W = CNT_W + DIM_W;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned PIPE_SLOTS = FIFO_DEPTH + 4;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_READ = 1'b1
  } cmd_e;

  typedef logic [DIM_W-1:0] dim_t;

  typedef struct packed {
    cmd_e                  cmd;
    logic [PIXEL_BITS-1:0] pixel;
  } entry_t;

  typedef struct packed {
    logic          wr;
    dim_t          src_w;
    dim_t          src_h;
    dim_t          dst_w;
    dim_t          dst_h;
    logic [ADDR_W:0] frame_size;
  } cfg_t;

endpackage

`default_nettype wire

// ----- hw/rtl/nearest_neighbor_image_scaler.sv -----
// Top level of the nearest-neighbor image scaler.
// Load items write source pixels in raster order into a 64K-entry frame store; read items
// return the next destination pixel in raster order, with frame_last set on the last one.
// In steady state one item of either kind is taken per cycle, unless the output stalls or
// a re-derivation runs; a read result passes through the intake register, the queue, two
// address stages and the registered store read. Source coordinates advance by stepping
// terms, so no division runs per pixel. Every configuration write starts a re-derivation of
// those terms on one serial divider: four divisions of 17 steps each, during which items
// queue up but are not carried out. The frame store is not cleared; a store entry must be
// loaded before it is read.
`default_nettype none

module nearest_neighbor_image_scaler import nnis_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  cmd_i,
  input  logic [PIXEL_BITS-1:0] pixel_in_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [PIXEL_BITS-1:0] pixel_out_o,
  output logic                  frame_last_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [DIM_W-1:0]      cfg_data_i
);

  logic   push, full, pop, empty;
  entry_t front_entry, queue_entry;
  cfg_t   cfg;

  nnis_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cmd_i       (cmd_i),
    .pixel_in_i  (pixel_in_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .push_o      (push),
    .entry_o     (front_entry),
    .full_i      (full),
    .cfg_o       (cfg)
  );

  nnis_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (front_entry),
    .full_o  (full),
    .pop_i   (pop),
    .entry_o (queue_entry),
    .empty_o (empty)
  );

  nnis_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .empty_i      (empty),
    .entry_i      (queue_entry),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .pixel_out_o  (pixel_out_o),
    .frame_last_o (frame_last_o)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/nnis_front.sv -----
// Front end of the scaler: item intake, command classification and configuration registers.
`default_nettype none

module nnis_front import nnis_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  cmd_i,
  input  logic [PIXEL_BITS-1:0] pixel_in_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  dim_t                  cfg_data_i,
  output logic                  push_o,
  output entry_t                entry_o,
  input  logic                  full_i,
  output cfg_t                  cfg_o
);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_WIDTH  = 2'd0,
    REG_SRC_HEIGHT = 2'd1,
    REG_DST_WIDTH  = 2'd2,
    REG_DST_HEIGHT = 2'd3
  } reg_idx_e;

  localparam dim_t MAX_W_DIM = DIM_W'(MAX_WIDTH);
  localparam dim_t MAX_H_DIM = DIM_W'(MAX_HEIGHT);
  localparam dim_t RESET_DIM = DIM_W'(256);

  function automatic dim_t clamp_dim(dim_t v, dim_t maxv);
    dim_t r;
    if (v == '0) begin
      r = dim_t'(1);
    end else if (v > maxv) begin
      r = maxv;
    end else begin
      r = v;
    end
    return r;
  endfunction

  entry_t          entry_q;
  logic            entry_valid_q, entry_valid_d;
  dim_t            src_w_q, src_h_q, dst_w_q, dst_h_q;
  logic [ADDR_W:0] frame_size_q, frame_size_d;
  dim_t            sw_c, sh_c, dw_c, dh_c;
  logic [2*DIM_W-1:0] size_prod;
  logic            accept;

  always_comb begin
    sw_c = clamp_dim(src_w_q, MAX_W_DIM);
    sh_c = clamp_dim(src_h_q, MAX_H_DIM);
    dw_c = clamp_dim(dst_w_q, MAX_W_DIM);
    dh_c = clamp_dim(dst_h_q, MAX_H_DIM);
    size_prod    = (2*DIM_W)'(sw_c) * (2*DIM_W)'(sh_c);
    frame_size_d = size_prod[ADDR_W:0];
  end

  assign in_stall_o = entry_valid_q && full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign push_o     = entry_valid_q && !full_i;
  assign entry_o    = entry_q;

  always_comb begin
    entry_valid_d = entry_valid_q;
    if (accept) begin
      entry_valid_d = 1'b1;
    end else if (push_o) begin
      entry_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_valid_q <= 1'b0;
      src_w_q       <= RESET_DIM;
      src_h_q       <= RESET_DIM;
      dst_w_q       <= RESET_DIM;
      dst_h_q       <= RESET_DIM;
      frame_size_q  <= (ADDR_W+1)'(MAX_WIDTH * MAX_HEIGHT);
    end else begin
      entry_valid_q <= entry_valid_d;
      frame_size_q  <= frame_size_d;
      if (cfg_we_i) begin
        unique case (reg_idx_e'(cfg_index_i))
          REG_SRC_WIDTH:  src_w_q <= cfg_data_i;
          REG_SRC_HEIGHT: src_h_q <= cfg_data_i;
          REG_DST_WIDTH:  dst_w_q <= cfg_data_i;
          REG_DST_HEIGHT: dst_h_q <= cfg_data_i;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      entry_q.cmd   <= cmd_e'(cmd_i);
      entry_q.pixel <= pixel_in_i;
    end
  end

  always_comb begin
    cfg_o.wr         = cfg_we_i;
    cfg_o.src_w      = sw_c;
    cfg_o.src_h      = sh_c;
    cfg_o.dst_w      = dw_c;
    cfg_o.dst_h      = dh_c;
    cfg_o.frame_size = frame_size_q;
  end

endmodule

`default_nettype wire

// ----- hw/rtl/nnis_fifo.sv -----
// Short command queue between the front end and the back end of the scaler.
`default_nettype none

module nnis_fifo import nnis_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t entry_i,
  output logic   full_o,
  input  logic   pop_i,
  output entry_t entry_o,
  output logic   empty_o
);

  entry_t                slots_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_PTR_W:0]   count_q;

  assign full_o  = (count_q == (FIFO_PTR_W+1)'(FIFO_DEPTH));
  assign empty_o = (count_q == '0);
  assign entry_o = slots_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/nnis_div.sv -----
// Serial restoring divider that derives the coordinate stepping terms.
`default_nettype none

module nnis_div import nnis_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [DIV_N_W-1:0] dividend_i,
  input  dim_t               divisor_i,
  output logic               done_o,
  output logic [DIV_N_W-1:0] quot_o,
  output dim_t               rem_o
);

  localparam int unsigned CNT_BITS = $clog2(DIV_N_W + 1);

  logic                busy_q, done_q;
  logic [CNT_BITS-1:0] cnt_q;
  logic [DIV_N_W-1:0]  quo_q;
  dim_t                rem_q, den_q, rem_step;
  logic [DIM_W:0]      trial, diff;
  logic                ge;

  always_comb begin
    trial    = {rem_q, quo_q[DIV_N_W-1]};
    diff     = trial - {1'b0, den_q};
    ge       = trial >= {1'b0, den_q};
    rem_step = ge ? diff[DIM_W-1:0] : trial[DIM_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_BITS'(DIV_N_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_BITS'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      den_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DIV_N_W-2:0], ge};
      rem_q <= rem_step;
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

// ----- hw/rtl/nnis_back.sv -----
// Back end of the scaler: coordinate stepping, address pipeline and frame store.
`default_nettype none

module nnis_back import nnis_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cfg_t                  cfg_i,
  input  logic                  empty_i,
  input  entry_t                entry_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [PIXEL_BITS-1:0] pixel_out_o,
  output logic                  frame_last_o
);

  localparam int unsigned PA_W = ROW_W + DIM_W;

  typedef enum logic [3:0] {
    RC_IDLE,
    RC_X_GO,
    RC_X_WAIT,
    RC_Y_GO,
    RC_Y_WAIT,
    RC_QX_GO,
    RC_QX_WAIT,
    RC_QY_GO,
    RC_QY_WAIT
  } rc_state_e;

  rc_state_e          rc_q;
  logic [COL_W-1:0]   col_q;
  logic [ROW_W-1:0]   row_q;
  logic [DIV_N_W-1:0] x_q, y_q, x_next, y_next;
  dim_t               xr_q, yr_q, rx_q, ry_q, qx_q, qy_q, xr_next, yr_next;
  logic [ADDR_W-1:0]  load_pos_q, load_next;
  logic [ADDR_W:0]    load_inc;

  logic [DIM_W:0]     xr_sum, yr_sum;
  logic               x_carry, y_carry, last_col, last_row, advance, pop, is_read;
  logic [COL_W-1:0]   xs;
  logic [ROW_W-1:0]   ys;

  logic               div_start, div_done;
  logic [DIV_N_W-1:0] div_dividend, div_quot;
  dim_t               div_divisor, div_rem;

  logic                  s1_valid_q, s2_valid_q, out_valid_q;
  cmd_e                  s1_cmd_q, s2_cmd_q;
  logic [COL_W-1:0]      s1_xs_q;
  logic [ROW_W-1:0]      s1_ys_q;
  logic                  s1_last_q, s2_last_q, out_last_q;
  logic [PIXEL_BITS-1:0] s1_pixel_q, s2_pixel_q, rdata_q;
  logic [ADDR_W-1:0]     s1_waddr_q, s2_addr_q, rd_addr;
  logic [PA_W-1:0]       rd_sum;

  logic [PIXEL_BITS-1:0] frame_mem [2**ADDR_W];

  assign advance = !(out_valid_q && out_stall_i);
  assign pop     = advance && !empty_i && (rc_q == RC_IDLE) && !cfg_i.wr;
  assign is_read = (entry_i.cmd == CMD_READ);
  assign pop_o   = pop;

  always_comb begin
    last_col = (DIV_N_W'(col_q) + DIV_N_W'(1)) >= DIV_N_W'(cfg_i.dst_w);
    last_row = (DIV_N_W'(row_q) + DIV_N_W'(1)) >= DIV_N_W'(cfg_i.dst_h);

    xr_sum  = {1'b0, xr_q} + {1'b0, rx_q};
    x_carry = xr_sum >= {1'b0, cfg_i.dst_w};
    xr_next = x_carry ? DIM_W'(xr_sum - {1'b0, cfg_i.dst_w}) : xr_sum[DIM_W-1:0];
    x_next  = x_q + DIV_N_W'(qx_q) + DIV_N_W'(x_carry);

    yr_sum  = {1'b0, yr_q} + {1'b0, ry_q};
    y_carry = yr_sum >= {1'b0, cfg_i.dst_h};
    yr_next = y_carry ? DIM_W'(yr_sum - {1'b0, cfg_i.dst_h}) : yr_sum[DIM_W-1:0];
    y_next  = y_q + DIV_N_W'(qy_q) + DIV_N_W'(y_carry);

    xs = (x_q >= DIV_N_W'(cfg_i.src_w)) ? COL_W'(cfg_i.src_w - dim_t'(1)) : x_q[COL_W-1:0];
    ys = (y_q >= DIV_N_W'(cfg_i.src_h)) ? ROW_W'(cfg_i.src_h - dim_t'(1)) : y_q[ROW_W-1:0];

    load_inc  = {1'b0, load_pos_q} + (ADDR_W+1)'(1);
    load_next = (load_inc >= cfg_i.frame_size) ? '0 : load_inc[ADDR_W-1:0];
  end

  always_comb begin
    div_start = 1'b0;
    unique case (rc_q)
      RC_X_GO, RC_X_WAIT: begin
        div_dividend = DIV_N_W'(col_q) * DIV_N_W'(cfg_i.src_w);
        div_divisor  = cfg_i.dst_w;
        div_start    = (rc_q == RC_X_GO);
      end
      RC_Y_GO, RC_Y_WAIT: begin
        div_dividend = DIV_N_W'(row_q) * DIV_N_W'(cfg_i.src_h);
        div_divisor  = cfg_i.dst_h;
        div_start    = (rc_q == RC_Y_GO);
      end
      RC_QX_GO, RC_QX_WAIT: begin
        div_dividend = DIV_N_W'(cfg_i.src_w);
        div_divisor  = cfg_i.dst_w;
        div_start    = (rc_q == RC_QX_GO);
      end
      RC_QY_GO, RC_QY_WAIT: begin
        div_dividend = DIV_N_W'(cfg_i.src_h);
        div_divisor  = cfg_i.dst_h;
        div_start    = (rc_q == RC_QY_GO);
      end
      default: begin
        div_dividend = '0;
        div_divisor  = dim_t'(1);
      end
    endcase
  end

  nnis_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rc_q       <= RC_IDLE;
      col_q      <= '0;
      row_q      <= '0;
      x_q        <= '0;
      y_q        <= '0;
      xr_q       <= '0;
      yr_q       <= '0;
      qx_q       <= dim_t'(1);
      qy_q       <= dim_t'(1);
      rx_q       <= '0;
      ry_q       <= '0;
      load_pos_q <= '0;
    end else begin
      if (cfg_i.wr) begin
        rc_q <= RC_X_GO;
      end else begin
        unique case (rc_q)
          RC_IDLE: begin
            if (pop && is_read) begin
              if (last_col) begin
                col_q <= '0;
                x_q   <= '0;
                xr_q  <= '0;
                if (last_row) begin
                  row_q <= '0;
                  y_q   <= '0;
                  yr_q  <= '0;
                end else begin
                  row_q <= row_q + 1'b1;
                  y_q   <= y_next;
                  yr_q  <= yr_next;
                end
              end else begin
                col_q <= col_q + 1'b1;
                x_q   <= x_next;
                xr_q  <= xr_next;
              end
            end
          end
          RC_X_GO:  rc_q <= RC_X_WAIT;
          RC_X_WAIT: begin
            if (div_done) begin
              x_q  <= div_quot;
              xr_q <= div_rem;
              rc_q <= RC_Y_GO;
            end
          end
          RC_Y_GO:  rc_q <= RC_Y_WAIT;
          RC_Y_WAIT: begin
            if (div_done) begin
              y_q  <= div_quot;
              yr_q <= div_rem;
              rc_q <= RC_QX_GO;
            end
          end
          RC_QX_GO: rc_q <= RC_QX_WAIT;
          RC_QX_WAIT: begin
            if (div_done) begin
              qx_q <= div_quot[DIM_W-1:0];
              rx_q <= div_rem;
              rc_q <= RC_QY_GO;
            end
          end
          RC_QY_GO: rc_q <= RC_QY_WAIT;
          RC_QY_WAIT: begin
            if (div_done) begin
              qy_q <= div_quot[DIM_W-1:0];
              ry_q <= div_rem;
              rc_q <= RC_IDLE;
            end
          end
          default: rc_q <= RC_IDLE;
        endcase
      end
      if (pop && !is_read) begin
        load_pos_q <= load_next;
      end
    end
  end

  always_comb begin
    rd_sum  = PA_W'(s1_ys_q) * PA_W'(cfg_i.src_w) + PA_W'(s1_xs_q);
    rd_addr = rd_sum[ADDR_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q  <= pop;
      s2_valid_q  <= s1_valid_q;
      out_valid_q <= s2_valid_q && (s2_cmd_q == CMD_READ);
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_cmd_q   <= entry_i.cmd;
      s1_xs_q    <= xs;
      s1_ys_q    <= ys;
      s1_last_q  <= last_col && last_row;
      s1_pixel_q <= entry_i.pixel;
      s1_waddr_q <= load_pos_q;
      s2_cmd_q   <= s1_cmd_q;
      s2_addr_q  <= (s1_cmd_q == CMD_READ) ? rd_addr : s1_waddr_q;
      s2_pixel_q <= s1_pixel_q;
      s2_last_q  <= s1_last_q;
      out_last_q <= s2_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && s2_valid_q) begin
      if (s2_cmd_q == CMD_LOAD) begin
        frame_mem[s2_addr_q] <= s2_pixel_q;
      end else begin
        rdata_q <= frame_mem[s2_addr_q];
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pixel_out_o  = rdata_q;
  assign frame_last_o = out_last_q;

endmodule

`default_nettype wire

// ----- hw/rtl/nnis_checker.sv -----
// Port-level checker for the nearest-neighbor image scaler and its bind statement.
`default_nettype none

module nnis_checker import nnis_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input logic                  cmd_i,
  input logic [PIXEL_BITS-1:0] pixel_in_i,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input logic [PIXEL_BITS-1:0] pixel_out_o,
  input logic                  frame_last_o,
  input logic                  cfg_we_i,
  input logic [CFG_IDX_W-1:0]  cfg_index_i,
  input logic [DIM_W-1:0]      cfg_data_i
);

  localparam int unsigned PEND_W = $clog2(PIPE_SLOTS + 1) + 1;

  logic [PEND_W-1:0] pending_q;
  logic              read_in, item_out;

  assign read_in  = in_valid_i && !in_stall_o && (cmd_i == CMD_READ);
  assign item_out = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else if (read_in && !item_out) begin
      pending_q <= pending_q + 1'b1;
    end else if (item_out && !read_in) begin
      pending_q <= pending_q - 1'b1;
    end
  end

  a_no_spurious_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (pending_q != '0))
    else $error("result item without an outstanding read");

  a_pending_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= PEND_W'(PIPE_SLOTS))
    else $error("more reads in flight than the design can hold");

  a_stalled_item_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(pixel_out_o) && $stable(frame_last_o))
    else $error("stalled result item changed");

  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o && !in_stall_o)
    else $error("handshake active during reset");

endmodule

bind nearest_neighbor_image_scaler nnis_checker u_checker (.*);

`default_nettype wire

// ----- test/nearest_neighbor_image_scaler_tb.sv -----
// Self-checking testbench of the nearest-neighbor image scaler, with directed and random items.
module nearest_neighbor_image_scaler_tb;
  import nnis_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned ITEM_TARGET = 1450;
  localparam int unsigned CALM_FROM   = 1250;
  localparam int unsigned DIR_ROWS    = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_W = 2'd0,
    REG_SRC_H = 2'd1,
    REG_DST_W = 2'd2,
    REG_DST_H = 2'd3
  } reg_e;

  typedef struct packed {
    logic [PIXEL_BITS-1:0] pixel;
    logic                  last;
  } dest_pixel_t;

  // A read row carries its expected pixel in the pixel field.
  typedef struct packed {
    logic                  is_cfg;
    reg_e                  sel;
    dim_t                  value;
    cmd_e                  cmd;
    logic [PIXEL_BITS-1:0] pixel;
    logic                  last;
  } dir_row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic                  cmd_i = CMD_LOAD;
  logic [PIXEL_BITS-1:0] pixel_in_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [PIXEL_BITS-1:0] pixel_out_o;
  logic                  frame_last_o;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [DIM_W-1:0]      cfg_data_i = '0;

  nearest_neighbor_image_scaler uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .cmd_i        (cmd_i),
    .pixel_in_i   (pixel_in_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .pixel_out_o  (pixel_out_o),
    .frame_last_o (frame_last_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  logic [PIXEL_BITS-1:0] shadow_store [STORE_DEPTH];
  bit                    loaded [STORE_DEPTH];
  dim_t                  reg_sw = dim_t'(256);
  dim_t                  reg_sh = dim_t'(256);
  dim_t                  reg_dw = dim_t'(256);
  dim_t                  reg_dh = dim_t'(256);
  int unsigned           load_pos = 0;
  int unsigned           out_row = 0;
  int unsigned           out_col = 0;

  dest_pixel_t due_pixels [$];
  dir_row_t    dir_rows [DIR_ROWS];

  bit          calm = 1'b0;
  int unsigned gap_odds = 4;
  int unsigned items_sent = 0;
  int unsigned reads_sent = 0;
  int unsigned settings_used = 0;
  int unsigned pixels_checked = 0;
  int unsigned frames_closed = 0;
  int unsigned bad_count = 0;
  int unsigned stall_left = 0;

  initial begin
    clk_i  = 1'b0;
    rst_ni = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic int unsigned eff_dim(input dim_t v, input int unsigned maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic int unsigned source_index();
    int unsigned sw, sh, dw, dh, x, y;
    sw = eff_dim(reg_sw, MAX_WIDTH);
    sh = eff_dim(reg_sh, MAX_HEIGHT);
    dw = eff_dim(reg_dw, MAX_WIDTH);
    dh = eff_dim(reg_dh, MAX_HEIGHT);
    x = (out_col * sw) / dw;
    y = (out_row * sh) / dh;
    if (x >= sw) x = sw - 1;
    if (y >= sh) y = sh - 1;
    return (y * sw + x) % STORE_DEPTH;
  endfunction

  function automatic dim_t raw_dim(input int unsigned d, input int unsigned maxv);
    if (d == 1 && $urandom_range(0, 2) == 0) return '0;
    if (d == maxv && $urandom_range(0, 2) == 0) return dim_t'($urandom_range(maxv + 1, 511));
    return dim_t'(d);
  endfunction

  function automatic logic [PIXEL_BITS-1:0] rand_pixel();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return PIXEL_BITS'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic dir_row_t cfg_row(input reg_e sel, input int unsigned value);
    return dir_row_t'{1'b1, sel, dim_t'(value), CMD_LOAD, '0, 1'b0};
  endfunction

  function automatic dir_row_t load_row(input logic [PIXEL_BITS-1:0] pixel);
    return dir_row_t'{1'b0, REG_SRC_W, '0, CMD_LOAD, pixel, 1'b0};
  endfunction

  function automatic dir_row_t read_row(input logic [PIXEL_BITS-1:0] pixel, input logic last);
    return dir_row_t'{1'b0, REG_SRC_W, '0, CMD_READ, pixel, last};
  endfunction

  task automatic advance_scaler(input cmd_e c, input logic [PIXEL_BITS-1:0] p);
    int unsigned sw, sh, dw, dh, idx;
    bit last_col, last_row;
    sw = eff_dim(reg_sw, MAX_WIDTH);
    sh = eff_dim(reg_sh, MAX_HEIGHT);
    dw = eff_dim(reg_dw, MAX_WIDTH);
    dh = eff_dim(reg_dh, MAX_HEIGHT);
    if (c == CMD_LOAD) begin
      shadow_store[load_pos] = p;
      loaded[load_pos] = 1'b1;
      load_pos++;
      if (load_pos >= sw * sh) load_pos = 0;
    end else begin
      idx = source_index();
      last_col = (out_col + 1) >= dw;
      last_row = (out_row + 1) >= dh;
      due_pixels.push_back(dest_pixel_t'{shadow_store[idx], last_col && last_row});
      reads_sent++;
      if (last_col) begin
        out_col = 0;
        out_row = last_row ? 0 : out_row + 1;
      end else begin
        out_col++;
      end
    end
  endtask

  task automatic send_item(input cmd_e c, input logic [PIXEL_BITS-1:0] p);
    if (items_sent >= CALM_FROM) calm = 1'b1;
    if (!calm && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i      <= c;
    pixel_in_i <= p;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
    advance_scaler(c, p);
  endtask

  task automatic set_dim(input reg_e sel, input dim_t value);
    in_valid_i <= 1'b0;
    while (due_pixels.size() != 0) @(posedge clk_i);
    repeat (24) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= sel;
    cfg_data_i  <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    repeat (90) @(posedge clk_i);
    case (sel)
      REG_SRC_W: reg_sw = value;
      REG_SRC_H: reg_sh = value;
      REG_DST_W: reg_dw = value;
      REG_DST_H: reg_dh = value;
    endcase
  endtask

  always @(posedge clk_i) begin
    if (calm || !rst_ni) begin
      stall_left = 0;
      out_stall_i <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      out_stall_i <= (stall_left != 0);
    end else if (gap_odds != 0 && $urandom_range(1, 2 * gap_odds) == 1) begin
      stall_left = $urandom_range(1, 12);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin : check_results
    dest_pixel_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (due_pixels.size() == 0) begin
        bad_count++;
        if (bad_count <= 10)
          $display("Unexpected output pixel %h (frame_last %b) at %0t", pixel_out_o,
                   frame_last_o, $realtime);
      end else begin
        want = due_pixels.pop_front();
        pixels_checked++;
        if (want.last) frames_closed++;
        if (pixel_out_o !== want.pixel || frame_last_o !== want.last) begin
          bad_count++;
          if (bad_count <= 10)
            $display("Mismatch at %0t: pixel exp %h got %h, frame_last exp %b got %b",
                     $realtime, want.pixel, pixel_out_o, want.last, frame_last_o);
        end
      end
    end
  end

  initial begin
    int unsigned sw, sh, dw, dh, span, read_pct;
    dir_rows = '{
      load_row(16'h0000), load_row(16'hFFFF), load_row(16'h5555), load_row(16'hAAAA),
      load_row(16'h8001),
      read_row(16'h0000, 1'b0), read_row(16'hFFFF, 1'b0), read_row(16'h5555, 1'b0),
      read_row(16'hAAAA, 1'b0), read_row(16'h8001, 1'b0),
      cfg_row(REG_SRC_W, 1), cfg_row(REG_SRC_H, 1), cfg_row(REG_DST_W, 1),
      cfg_row(REG_DST_H, 1),
      read_row(16'h0000, 1'b1),
      load_row(16'h1234), load_row(16'h4321),
      read_row(16'h4321, 1'b1),
      cfg_row(REG_SRC_W, 0), cfg_row(REG_SRC_H, 511), cfg_row(REG_DST_W, 511),
      cfg_row(REG_DST_H, 0),
      read_row(16'h4321, 1'b0), read_row(16'h4321, 1'b0)
    };

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The first rows run with the dimensions left by reset.
    foreach (dir_rows[k]) begin
      if (dir_rows[k].is_cfg) begin
        set_dim(dir_rows[k].sel, dir_rows[k].value);
      end else if (dir_rows[k].cmd == CMD_LOAD) begin
        send_item(CMD_LOAD, dir_rows[k].pixel);
      end else begin
        send_item(CMD_READ, rand_pixel());
        due_pixels[due_pixels.size() - 1] = dest_pixel_t'{dir_rows[k].pixel, dir_rows[k].last};
      end
    end

    while (items_sent < ITEM_TARGET) begin
      case ($urandom_range(0, 7))
        0: begin sw = MAX_WIDTH; sh = $urandom_range(1, 2); end
        1: begin sw = $urandom_range(1, 2); sh = MAX_HEIGHT; end
        2: begin sw = 1; sh = 1; end
        default: begin sw = $urandom_range(1, 16); sh = $urandom_range(1, 16); end
      endcase
      case ($urandom_range(0, 7))
        0: begin dw = MAX_WIDTH; dh = $urandom_range(1, 3); end
        1: begin dw = $urandom_range(1, 3); dh = MAX_HEIGHT; end
        2: begin dw = 1; dh = 1; end
        default: begin dw = $urandom_range(1, 24); dh = $urandom_range(1, 24); end
      endcase
      if (items_sent >= CALM_FROM) calm = 1'b1;
      set_dim(REG_SRC_W, raw_dim(sw, MAX_WIDTH));
      set_dim(REG_SRC_H, raw_dim(sh, MAX_HEIGHT));
      set_dim(REG_DST_W, raw_dim(dw, MAX_WIDTH));
      set_dim(REG_DST_H, raw_dim(dh, MAX_HEIGHT));
      settings_used++;
      case ($urandom_range(0, 2))
        0: gap_odds = 0;
        1: gap_odds = 3;
        default: gap_odds = 8;
      endcase

      // Most settings get a whole source frame before reading; the rest read what is there.
      if ($urandom_range(0, 4) != 0)
        repeat ((sw * sh > 600) ? 600 : sw * sh)
          if (items_sent < ITEM_TARGET) send_item(CMD_LOAD, rand_pixel());

      span = $urandom_range(60, 120);
      read_pct = $urandom_range(60, 90);
      repeat (span) begin
        if (items_sent >= ITEM_TARGET)
          break;
        if (loaded[source_index()] && $urandom_range(1, 100) <= read_pct)
          send_item(CMD_READ, rand_pixel());
        else
          send_item(CMD_LOAD, rand_pixel());
      end
    end

    in_valid_i <= 1'b0;
    while (due_pixels.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Sent %0d items (%0d reads) across %0d random dimension settings.",
             items_sent, reads_sent, settings_used);
    $display("Checked %0d output pixels, %0d closing a frame; %0d mismatches.",
             pixels_checked, frames_closed, bad_count);
    if (bad_count == 0 && due_pixels.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
